FILE: rtl/core/fit_policy_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fit-policy block allocator
// Concurrent checks sampled at the rising clock edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define FPBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Types and codes shared by the fit-policy block allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

    localparam int SIZE_W   = 16;
    localparam int CIDX_W   = 4;
    localparam int BIU_W    = 5;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Fit policy codes (the unused code acts as first fit)
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADLOAD = 2'd2;

    // One table entry
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              taken;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/fpba_table.sv
// ----------------------------------------------------------------------------
// fpba_table
// Block table memory: one write port, one registered read port. Per-entry
// valid bits make an unwritten entry read as zero size, not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_table
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [IW-1:0] i_rd_addr,
    output t_entry             o_rd_data
);

    t_entry                r_mem [NUM_BLOCKS];
    t_entry                r_rd_data;
    logic [NUM_BLOCKS-1:0] r_vld;
    logic                  r_rd_vld;

    // Storage array, read data registered
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Written-entry flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: rtl/core/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Block table with load and first / best / worst fit allocate commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (i_in_valid / o_in_stall) carry a command: load writes a
//   block size into one table entry and frees it; allocate scans the first
//   blocks_in_use entries and marks the chosen one taken. Each input word
//   produces exactly one output word (o_out_valid / i_out_stall) with a
//   status and the entry index.
//   The user writes blocks_in_use through i_cfg_we / i_cfg_wdata only while
//   idle; the block itself does not enforce it. One word is in work at a
//   time. A load result goes through the result state into the output
//   register. An allocate reads the first n table entries, where n is the
//   effective blocks_in_use, one entry per cycle through the registered
//   read port, then ends the scan, writes back the taken flag (skipped
//   when nothing fits) and goes to the result state. The next word can be
//   taken in the cycle after the result is loaded into the output
//   register. Reset empties the table (all sizes zero, all free) and sets
//   blocks_in_use to 16. When the receiver stalls, the finished result
//   waits in the output register; a newer result waits in its own state
//   until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fit_policy_block_allocator_defines.svh"

module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic [BIU_W-1:0]  i_cfg_wdata,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_cmd,
    input  wire logic [1:0]        i_fit_policy,
    input  wire logic [3:0]        i_load_index,
    input  wire logic [SIZE_W-1:0] i_load_size,
    input  wire logic [SIZE_W-1:0] i_request_size,
    // output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_status,
    output logic [CIDX_W-1:0]      o_chosen_index
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    t_state             r_state;
    t_state             n_state;
    logic [BIU_W-1:0]   r_biu;
    logic [CW-1:0]      w_span;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_issue;
    logic               r_eval_pend;
    logic [IW-1:0]      r_eval_idx;
    logic [SIZE_W-1:0]  r_req;
    logic [1:0]         r_policy;
    logic               r_found;
    logic [IW-1:0]      r_pick;
    logic [SIZE_W-1:0]  r_pick_size;
    logic [1:0]         r_res_status;
    logic [IW-1:0]      r_res_idx;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [CIDX_W-1:0]  r_chosen;

    logic               w_accept;
    logic               w_load_ok;
    logic               w_issue;
    logic               w_scan_done;
    logic               w_fits;
    logic               w_take;
    logic               w_res_load;
    logic               w_rd_en;
    logic [IW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic [IW-1:0]      w_wr_addr;
    t_entry             w_wr_data;
    t_entry             w_rd_data;

    // Effective span: blocks_in_use clamped to the table depth
    assign w_span = (int'(r_biu) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(r_biu);

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_load_ok   = int'(i_load_index) < int'(w_span);
    assign w_issue     = (r_state == S_SCAN) && (r_issue < r_n);
    assign w_scan_done = (r_state == S_SCAN) && (r_issue == r_n) && !r_eval_pend;
    assign w_res_load  = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);

    // Candidate test on the entry read last cycle
    assign w_fits = r_eval_pend && !w_rd_data.taken && (w_rd_data.size >= r_req);
    always_comb begin
        w_take = 1'b0;
        if (w_fits) begin
            if (!r_found) begin
                w_take = 1'b1;
            end else if (r_policy == POL_BEST) begin
                w_take = w_rd_data.size < r_pick_size;
            end else if (r_policy == POL_WORST) begin
                w_take = w_rd_data.size > r_pick_size;
            end
        end
    end

    // Table memory
    fpba_table #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_cmd == CMD_ALLOC) ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = r_found ? S_WRITE : S_RESULT;
                end
            end
            S_WRITE: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_res_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs: stall, memory ports
    always_comb begin
        o_in_stall = 1'b1;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_issue[IW-1:0];
        w_wr_en    = 1'b0;
        w_wr_addr  = IW'(i_load_index);
        w_wr_data  = '{size: i_load_size, taken: 1'b0};
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                w_wr_en    = w_accept && (i_cmd == CMD_LOAD) && w_load_ok;
            end
            S_SCAN: begin
                w_rd_en = w_issue;
            end
            S_WRITE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pick;
                w_wr_data = '{size: r_pick_size, taken: 1'b1};
            end
            S_RESULT: begin
                o_in_stall = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_biu       <= BIU_W'(16);
            r_issue     <= '0;
            r_eval_pend <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_biu <= i_cfg_wdata;
            end
            // scan sequencing
            if (w_accept) begin
                r_issue     <= '0;
                r_eval_pend <= 1'b0;
                r_found     <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_eval_pend <= w_issue;
                if (w_issue) begin
                    r_issue <= r_issue + 1'b1;
                end
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end
            // output register
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n      <= w_span;
            r_req    <= i_request_size;
            r_policy <= i_fit_policy;
            if (i_cmd == CMD_LOAD) begin
                r_res_status <= w_load_ok ? ST_OK : ST_BADLOAD;
                r_res_idx    <= w_load_ok ? IW'(i_load_index) : '0;
            end
        end
        if (r_state == S_SCAN) begin
            r_eval_idx <= r_issue[IW-1:0];
            if (w_take) begin
                r_pick      <= r_eval_idx;
                r_pick_size <= w_rd_data.size;
            end
            if (w_scan_done) begin
                r_res_status <= r_found ? ST_OK : ST_NOFIT;
                r_res_idx    <= r_found ? r_pick : '0;
            end
        end
        if (w_res_load) begin
            r_status <= r_res_status;
            r_chosen <= CIDX_W'(r_res_idx);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_chosen_index = r_chosen;

    // Checks
    `FPBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state != S_IDLE, "accepted word did not start work")
    `FPBA_ASSERT_IMPL(a_err_zero_idx, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_chosen_index == '0, "failed result carries nonzero index")
    `FPBA_ASSERT_IMPL(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_issue <= r_n, "scan ran past span")
    `FPBA_ASSERT_IMPL(a_write_found, i_clk, i_rst_n, r_state == S_WRITE, r_found, "taken write without a chosen block")

endmodule

`default_nettype wire
